/* rtl/erm_pkg.sv */
`timescale 1ns / 1ps
package erm_pkg;

  localparam int ANGLE_W = 18;
  localparam int ORDER_W = 3;
  localparam int OUT_W   = 16;
  localparam int R_W     = 17;
  localparam int M_W     = 15;
  localparam int HI_W    = 42;
  localparam int LO_W    = 30;
  localparam int V_W     = 20;
  localparam int RQ_W    = 47;
  localparam int XY_W    = 34;
  localparam int Z_W     = 44;
  localparam int MAX_STAGES = 30;
  localparam int OUT_FB  = 14;
  localparam int OUT_LIM = 16384;

  localparam logic signed [19:0] FULL_TURN = 20'sd92160;
  localparam logic signed [19:0] TWO_TURNS = 20'sd184320;
  localparam logic [R_W-1:0] QTR1 = 17'd23040;
  localparam logic [R_W-1:0] QTR2 = 17'd46080;
  localparam logic [R_W-1:0] QTR3 = 17'd69120;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint PI40 = longint'((PI_Q60 + 64'd524288) >> 20);
  localparam longint PI_DEN = 46080;
  // t = m*RAD_Q + ((m*RAD_R + 23040) >> 10) / 45
  localparam logic [26:0] RAD_Q = 27'(PI40 / PI_DEN);
  localparam logic [14:0] RAD_R = 15'(PI40 % PI_DEN);
  localparam logic [30:0] RAD_BIAS = 31'd23040;
  localparam int RAD_SHIFT = 10;
  localparam logic [26:0] RECIP45 = 27'(((64'd1 << 32) + 64'd44) / 64'd45);
  localparam int RECIP_SHIFT = 32;

  localparam logic signed [XY_W-1:0] CORDIC_K = 34'sh026DD3B6A;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [ORDER_W-1:0] {
    ORD_XYZ = 3'd0,
    ORD_YXZ = 3'd1,
    ORD_YZX = 3'd2,
    ORD_XZY = 3'd3,
    ORD_ZYX = 3'd4,
    ORD_ZXY = 3'd5
  } order_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef longint atan_tab_t [MAX_STAGES];

  // restoring division, elaboration only
  function automatic longint cdiv(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'sd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'sd1 << b);
      end
    end
    return q;
  endfunction

  function automatic longint atan_q40(int i);
    longint sum;
    longint term;
    sum = 0;
    if (i == 0) begin
      return PI40 >>> 2;
    end
    for (int k = 0; i * (2 * k + 1) <= 40; k++) begin
      term = cdiv(longint'(1) << (40 - i * (2 * k + 1)), longint'(2 * k + 1));
      sum = ((k & 1) != 0) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    for (int i = 0; i < MAX_STAGES; i++) begin
      t[i] = atan_q40(i);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

/* rtl/erm_angles_if.sv */
`timescale 1ns / 1ps
interface erm_angles_if;
  import erm_pkg::*;
  logic valid;
  logic ready;
  logic signed [ANGLE_W-1:0] angle_x;
  logic signed [ANGLE_W-1:0] angle_y;
  logic signed [ANGLE_W-1:0] angle_z;
  logic [ORDER_W-1:0] axis_order;
  modport source (output valid, angle_x, angle_y, angle_z, axis_order, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, axis_order, output ready);
endinterface

/* rtl/erm_matrix_if.sv */
`timescale 1ns / 1ps
interface erm_matrix_if;
  import erm_pkg::*;
  logic valid;
  logic ready;
  logic signed [OUT_W-1:0] r00;
  logic signed [OUT_W-1:0] r01;
  logic signed [OUT_W-1:0] r02;
  logic signed [OUT_W-1:0] r10;
  logic signed [OUT_W-1:0] r11;
  logic signed [OUT_W-1:0] r12;
  logic signed [OUT_W-1:0] r20;
  logic signed [OUT_W-1:0] r21;
  logic signed [OUT_W-1:0] r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

/* rtl/euler_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// channel   dir   payload
// angles    in    angle_x, angle_y, angle_z, axis_order
// matrix    out   r00 r01 r02 r10 r11 r12 r20 r21 r22
//
// one item per cycle sustained while neither end stalls; the path runs through
// angle reduction, the cordic stages, the queue, two matrix products and output
// rst is synchronous and clears every valid bit and the queue pointers
// the front stalls only when the four-entry queue is full; the back stalls
// only when its output register holds an item that is not taken
module euler_to_rotation_matrix #(
  parameter int COEF_WIDTH    = 16,
  parameter int SINCOS_STAGES = 16
) (
  input logic clk,
  input logic rst,
  erm_angles_if.sink angles,
  erm_matrix_if.source matrix
);
  import erm_pkg::*;

  localparam int QW = 6 * COEF_WIDTH + ORDER_W;

  q_stat_t q_stat;
  logic push;
  logic pop;
  logic signed [COEF_WIDTH-1:0] f_sin [3];
  logic signed [COEF_WIDTH-1:0] f_cos [3];
  logic [ORDER_W-1:0] f_ord;
  logic signed [COEF_WIDTH-1:0] b_sin [3];
  logic signed [COEF_WIDTH-1:0] b_cos [3];
  logic [ORDER_W-1:0] b_ord;
  logic [QW-1:0] wdata;
  logic [QW-1:0] rdata;
  logic signed [OUT_W-1:0] r [9];

  erm_front #(
    .COEF_WIDTH   (COEF_WIDTH),
    .SINCOS_STAGES(SINCOS_STAGES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(angles.valid),
    .ready   (angles.ready),
    .angle_x (angles.angle_x),
    .angle_y (angles.angle_y),
    .angle_z (angles.angle_z),
    .order_in(angles.axis_order),
    .q_stat  (q_stat),
    .push    (push),
    .sin_o   (f_sin),
    .cos_o   (f_cos),
    .order_o (f_ord)
  );

  assign wdata = {f_ord, f_sin[0], f_sin[1], f_sin[2], f_cos[0], f_cos[1], f_cos[2]};
  assign {b_ord, b_sin[0], b_sin[1], b_sin[2], b_cos[0], b_cos[1], b_cos[2]} = rdata;

  erm_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wdata),
    .pop  (pop),
    .rdata(rdata),
    .stat (q_stat)
  );

  erm_back #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop      (pop),
    .sin_i    (b_sin),
    .cos_i    (b_cos),
    .order_i  (b_ord),
    .out_ready(matrix.ready),
    .out_valid(matrix.valid),
    .r        (r)
  );

  assign matrix.r00 = r[0];
  assign matrix.r01 = r[1];
  assign matrix.r02 = r[2];
  assign matrix.r10 = r[3];
  assign matrix.r11 = r[4];
  assign matrix.r12 = r[5];
  assign matrix.r20 = r[6];
  assign matrix.r21 = r[7];
  assign matrix.r22 = r[8];

endmodule

/* rtl/erm_front.sv */
`timescale 1ns / 1ps
module erm_front #(
  parameter int COEF_WIDTH    = 16,
  parameter int SINCOS_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic ready,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_x,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_y,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_z,
  input  logic [erm_pkg::ORDER_W-1:0] order_in,
  input  erm_pkg::q_stat_t q_stat,
  output logic push,
  output logic signed [COEF_WIDTH-1:0] sin_o [3],
  output logic signed [COEF_WIDTH-1:0] cos_o [3],
  output logic [erm_pkg::ORDER_W-1:0] order_o
);
  import erm_pkg::*;

  localparam int S  = SINCOS_STAGES;
  localparam int D  = S + 5;
  localparam int FB = COEF_WIDTH - 2;
  localparam int SH = 30 - FB;
  localparam logic signed [XY_W:0] HALF = (SH > 0) ? (XY_W+1)'(64'd1 << (SH - 1)) : '0;
  localparam logic signed [XY_W:0] ONE = (XY_W+1)'(64'd1 << FB);
  localparam logic signed [COEF_WIDTH-1:0] ONE_C = COEF_WIDTH'(64'd1 << FB);

  logic en;
  logic [D-1:0] vld;
  logic [ORDER_W-1:0] ord [D];
  logic signed [ANGLE_W-1:0] angle [3];

  assign angle[0] = angle_x;
  assign angle[1] = angle_y;
  assign angle[2] = angle_z;

  assign en    = !(vld[D-1] && q_stat.full);
  assign ready = en;
  assign push  = vld[D-1] && !q_stat.full;
  assign order_o = ord[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ord[0] <= order_in;
      for (int i = 1; i < D; i++) begin
        ord[i] <= ord[i-1];
      end
    end
  end

  function automatic logic signed [COEF_WIDTH-1:0] to_coef(logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] r;
    r = ((XY_W+1)'(v) + HALF) >>> SH;
    if (r > ONE) begin
      r = ONE;
    end else if (r < -ONE) begin
      r = -ONE;
    end
    return COEF_WIDTH'(r);
  endfunction

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [19:0] ae;
    logic signed [19:0] rs;
    logic [R_W-1:0] rr;
    logic [1:0] qc;
    logic [M_W-1:0] mc;
    logic [1:0] q1;
    logic [M_W-1:0] m1;
    logic [1:0] q2;
    logic z2;
    logic [HI_W-1:0] hi2;
    logic [LO_W-1:0] lo2;
    logic [1:0] q3;
    logic z3;
    logic [HI_W-1:0] hi3;
    logic [RQ_W-1:0] rq3;
    logic [V_W-1:0] v2;
    logic signed [XY_W-1:0] cx [S+1];
    logic signed [XY_W-1:0] cy [S+1];
    logic signed [Z_W-1:0] cz [S+1];
    logic [1:0] cq [S+1];
    logic czf [S+1];
    logic signed [COEF_WIDTH-1:0] sc;
    logic signed [COEF_WIDTH-1:0] cc;
    logic signed [COEF_WIDTH-1:0] sreg;
    logic signed [COEF_WIDTH-1:0] creg;

    // wrap to one turn, then split into quadrant and remainder
    always_comb begin
      ae = 20'(angle[l]);
      if (ae < -FULL_TURN) begin
        rs = ae + TWO_TURNS;
      end else if (ae < 20'sd0) begin
        rs = ae + FULL_TURN;
      end else if (ae >= FULL_TURN) begin
        rs = ae - FULL_TURN;
      end else begin
        rs = ae;
      end
      rr = rs[R_W-1:0];
      if (rr >= QTR3) begin
        qc = 2'd3;
        mc = M_W'(rr - QTR3);
      end else if (rr >= QTR2) begin
        qc = 2'd2;
        mc = M_W'(rr - QTR2);
      end else if (rr >= QTR1) begin
        qc = 2'd1;
        mc = M_W'(rr - QTR1);
      end else begin
        qc = 2'd0;
        mc = rr[M_W-1:0];
      end
    end

    assign v2 = V_W'((31'(lo2) + RAD_BIAS) >> RAD_SHIFT);

    always_ff @(posedge clk) begin
      if (en) begin
        q1     <= qc;
        m1     <= mc;
        q2     <= q1;
        z2     <= (m1 == '0);
        hi2    <= HI_W'(m1) * HI_W'(RAD_Q);
        lo2    <= LO_W'(m1) * LO_W'(RAD_R);
        q3     <= q2;
        z3     <= z2;
        hi3    <= hi2;
        rq3    <= RQ_W'(v2) * RQ_W'(RECIP45);
        cx[0]  <= CORDIC_K;
        cy[0]  <= '0;
        cz[0]  <= $signed(Z_W'(hi3 + HI_W'(rq3[RQ_W-1:RECIP_SHIFT])));
        cq[0]  <= q3;
        czf[0] <= z3;
      end
    end

    for (genvar k = 0; k < S; k++) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz[k][Z_W-1]) begin
            cx[k+1] <= cx[k] - (cy[k] >>> k);
            cy[k+1] <= cy[k] + (cx[k] >>> k);
            cz[k+1] <= cz[k] - Z_W'(ATAN_TAB[k]);
          end else begin
            cx[k+1] <= cx[k] + (cy[k] >>> k);
            cy[k+1] <= cy[k] - (cx[k] >>> k);
            cz[k+1] <= cz[k] + Z_W'(ATAN_TAB[k]);
          end
          cq[k+1]  <= cq[k];
          czf[k+1] <= czf[k];
        end
      end
    end

    always_comb begin
      if (czf[S]) begin
        sc = '0;
        cc = ONE_C;
      end else begin
        sc = to_coef(cy[S]);
        cc = to_coef(cx[S]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        case (cq[S])
          2'd0: begin
            sreg <= sc;
            creg <= cc;
          end
          2'd1: begin
            sreg <= cc;
            creg <= -sc;
          end
          2'd2: begin
            sreg <= -sc;
            creg <= -cc;
          end
          default: begin
            sreg <= -cc;
            creg <= sc;
          end
        endcase
      end
    end

    assign sin_o[l] = sreg;
    assign cos_o[l] = creg;
  end

endmodule

/* rtl/erm_queue.sv */
`timescale 1ns / 1ps
module erm_queue #(
  parameter int WIDTH = 99
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] wdata,
  input  logic pop,
  output logic [WIDTH-1:0] rdata,
  output erm_pkg::q_stat_t stat
);
  import erm_pkg::*;

  logic [WIDTH-1:0] mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0] count;

  assign stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/erm_back.sv */
`timescale 1ns / 1ps
module erm_back #(
  parameter int COEF_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  erm_pkg::q_stat_t q_stat,
  output logic pop,
  input  logic signed [COEF_WIDTH-1:0] sin_i [3],
  input  logic signed [COEF_WIDTH-1:0] cos_i [3],
  input  logic [erm_pkg::ORDER_W-1:0] order_i,
  input  logic out_ready,
  output logic out_valid,
  output logic signed [erm_pkg::OUT_W-1:0] r [9]
);
  import erm_pkg::*;

  localparam int CW = COEF_WIDTH;
  localparam int FB = CW - 2;
  localparam int PW = 2 * CW;
  localparam int SW = 2 * CW + 2;
  localparam int OW = CW + 16;
  localparam int DN = (FB >= OUT_FB) ? FB - OUT_FB : 0;
  localparam int UP = (FB < OUT_FB) ? OUT_FB - FB : 0;
  localparam logic signed [CW-1:0] ONE_C = CW'(64'd1 << FB);
  localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << FB);
  localparam logic signed [SW-1:0] HALF_S = SW'(64'd1 << (FB - 1));
  localparam logic signed [OW-1:0] HALF_O = (DN > 0) ? OW'(64'd1 << (DN - 1)) : '0;
  localparam logic signed [OW-1:0] LIM_O = OW'(OUT_LIM);

  typedef logic signed [CW-1:0] mat_t [3][3];
  typedef logic signed [PW-1:0] prod_t [3][3][3];

  logic en;
  logic [5:0] vb;
  order_t ord;
  mat_t mx, my, mz, sa, sb, sc;
  mat_t pa, pb, pc0, pc1, pc2, tm, rm;
  prod_t pr1, pr2;
  logic signed [OUT_W-1:0] ro [9];

  assign en  = !vb[5] || out_ready;
  assign pop = en && !q_stat.empty;
  assign out_valid = vb[5];
  assign ord = order_t'(order_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[4:0], !q_stat.empty};
    end
  end

  function automatic logic signed [CW-1:0] mat_rnd(logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = (s + HALF_S) >>> FB;
    if (v > ONE_S) begin
      v = ONE_S;
    end else if (v < -ONE_S) begin
      v = -ONE_S;
    end
    return CW'(v);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(logic signed [CW-1:0] x);
    logic signed [OW-1:0] v;
    v = ((OW'(x) + HALF_O) >>> DN) <<< UP;
    if (v > LIM_O) begin
      v = LIM_O;
    end else if (v < -LIM_O) begin
      v = -LIM_O;
    end
    return OUT_W'(v);
  endfunction

  always_comb begin
    mx = '{'{ONE_C, '0, '0}, '{'0, cos_i[0], -sin_i[0]}, '{'0, sin_i[0], cos_i[0]}};
    my = '{'{cos_i[1], '0, sin_i[1]}, '{'0, ONE_C, '0}, '{-sin_i[1], '0, cos_i[1]}};
    mz = '{'{cos_i[2], -sin_i[2], '0}, '{sin_i[2], cos_i[2], '0}, '{'0, '0, ONE_C}};
    unique case (ord)
      ORD_XYZ: begin sa = mx; sb = my; sc = mz; end
      ORD_YXZ: begin sa = my; sb = mx; sc = mz; end
      ORD_YZX: begin sa = my; sb = mz; sc = mx; end
      ORD_XZY: begin sa = mx; sb = mz; sc = my; end
      ORD_ZXY: begin sa = mz; sb = mx; sc = my; end
      default: begin sa = mz; sb = my; sc = mx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa  <= sa;
      pb  <= sb;
      pc0 <= sc;
      pc1 <= pc0;
      pc2 <= pc1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pr1[i][j][k] <= PW'(pa[i][k]) * PW'(pb[k][j]);
            pr2[i][j][k] <= PW'(tm[i][k]) * PW'(pc2[k][j]);
          end
          tm[i][j] <= mat_rnd(SW'(pr1[i][j][0]) + SW'(pr1[i][j][1]) + SW'(pr1[i][j][2]));
          rm[i][j] <= mat_rnd(SW'(pr2[i][j][0]) + SW'(pr2[i][j][1]) + SW'(pr2[i][j][2]));
          ro[i*3+j] <= to_out(rm[i][j]);
        end
      end
    end
  end

  assign r = ro;

endmodule

/* rtl/erm_chk.sv */
`timescale 1ns / 1ps
module erm_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] r00,
  input logic [15:0] r22
);

  logic in_xfer;
  logic out_xfer;
  logic [7:0] pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pending != 8'd0)
    else $error("result transfer without a pending item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(r00) && $stable(r22))
    else $error("result changed while stalled");

endmodule

bind euler_to_rotation_matrix erm_chk u_erm_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (angles.valid),
  .in_ready (angles.ready),
  .out_valid(matrix.valid),
  .out_ready(matrix.ready),
  .r00      (matrix.r00),
  .r22      (matrix.r22)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import erm_pkg::*;

  localparam int COEF_W = 16;
  localparam int STAGES = 16;
  localparam int FRAC = COEF_W - 2;
  localparam logic [63:0] PI_Q60_K = 64'h3243F6A8885A308D;
  localparam longint PI_Q40 = longint'((PI_Q60_K + 64'd524288) >> 20);

  typedef longint mat3_t [0:2][0:2];

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  erm_angles_if angles ();
  erm_matrix_if matrix ();

  euler_to_rotation_matrix #(.COEF_WIDTH(COEF_W), .SINCOS_STAGES(STAGES)) u_dut (
    .clk(clk),
    .rst(rst),
    .angles(angles),
    .matrix(matrix)
  );

  longint atan_tab [MAX_STAGES];
  logic [143:0] matrix_q [$];
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int ready_mode = 0;
  int cyc = 0;

  function automatic longint round_sh(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint arctan_q40(int i);
    longint acc;
    acc = 0;
    if (i == 0) return PI_Q40 >>> 2;
    for (int k = 0; i * (2 * k + 1) <= 40; k++) begin
      if (k % 2 == 1) acc -= (longint'(1) << (40 - i * (2 * k + 1))) / (2 * k + 1);
      else acc += (longint'(1) << (40 - i * (2 * k + 1))) / (2 * k + 1);
    end
    return acc;
  endfunction

  task automatic sin_cos(input logic signed [ANGLE_W-1:0] ang, output longint so,
                         output longint co);
    longint a, r, m, x, y, z, dx, dy, s, c, one;
    int q;
    one = longint'(1) << FRAC;
    a = ang;
    r = a % 92160;
    if (r < 0) r += 92160;
    q = int'(r / 23040);
    m = r % 23040;
    if (m == 0) begin
      s = 0;
      c = one;
    end else begin
      z = (m * PI_Q40 + 23040) / 46080;
      x = 64'sh26DD3B6A;
      y = 0;
      for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      c = clip(round_sh(x, 30 - FRAC), one);
      s = clip(round_sh(y, 30 - FRAC), one);
    end
    case (q)
      0: begin so = s; co = c; end
      1: begin so = c; co = -s; end
      2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
  endtask

  task automatic mat_product(input mat3_t a, input mat3_t b, output mat3_t d);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        d[i][j] = clip(round_sh(acc, FRAC), longint'(1) << FRAC);
      end
  endtask

  task automatic predict_matrix(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                                input logic [ANGLE_W-1:0] az, input logic [ORDER_W-1:0] ord,
                                output logic [143:0] res);
    longint sx, cx, sy, cy, sz, cz, one, v;
    mat3_t mx, my, mz, p1, p2, p3, t, prod;
    one = longint'(1) << FRAC;
    sin_cos(ax, sx, cx);
    sin_cos(ay, sy, cy);
    sin_cos(az, sz, cz);
    mx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
    my = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
    mz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
    case (ord)
      ORD_XYZ: begin p1 = mx; p2 = my; p3 = mz; end
      ORD_YXZ: begin p1 = my; p2 = mx; p3 = mz; end
      ORD_YZX: begin p1 = my; p2 = mz; p3 = mx; end
      ORD_XZY: begin p1 = mx; p2 = mz; p3 = my; end
      ORD_ZXY: begin p1 = mz; p2 = mx; p3 = my; end
      default: begin p1 = mz; p2 = my; p3 = mx; end
    endcase
    mat_product(p1, p2, t);
    mat_product(t, p3, prod);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = prod[i][j];
        if (FRAC >= OUT_FB) v = round_sh(v, FRAC - OUT_FB);
        else v = v * (longint'(1) << (OUT_FB - FRAC));
        v = clip(v, OUT_LIM);
        res[(i * 3 + j) * 16 +: 16] = v[15:0];
      end
  endtask

  task automatic send_angles(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                             input logic [ANGLE_W-1:0] az, input logic [ORDER_W-1:0] ord);
    logic [143:0] res;
    angles.valid <= 1'b1;
    angles.angle_x <= ax;
    angles.angle_y <= ay;
    angles.angle_z <= az;
    angles.axis_order <= ord;
    do @(posedge clk); while (!angles.ready);
    predict_matrix(ax, ay, az, ord, res);
    matrix_q.push_back(res);
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      angles.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle(int kind);
    int sel;
    sel = $urandom_range(0, 9);
    if (kind == 0 || sel < 2)
      return ANGLE_W'(23040 * ($urandom_range(0, 10) - 5) + $urandom_range(0, 2) - 1);
    if (kind == 1 || sel < 7) return ANGLE_W'(int'($urandom_range(0, 184320)) - 92160);
    return ANGLE_W'($urandom_range(0, 262143));
  endfunction

  // bursts of random length, random gaps, sometimes long gap-free runs
  task automatic send_stream(int count, int kind);
    int burst;
    int gap_max;
    while (count > 0) begin
      burst = $urandom_range(1, 16);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      for (int b = 0; b < burst && count > 0; b++) begin
        send_angles(pick_angle(kind), pick_angle(kind), pick_angle(kind),
                    ORDER_W'($urandom_range(0, 7)));
        count--;
      end
      idle_cycles($urandom_range(0, gap_max));
    end
  endtask

  task automatic test_directed();
    logic [ANGLE_W-1:0] ext [6];
    ext = '{18'h20000, 18'h1FFFF, ANGLE_W'(-92160), ANGLE_W'(92160), 18'd0, 18'd1};
    for (int o = 0; o < 8; o++)
      send_angles(ANGLE_W'(1280 * (o + 1)), ANGLE_W'(-3840 * o - 7), ANGLE_W'(5000 + o),
                  ORDER_W'(o));
    for (int i = 0; i < 6; i++)
      send_angles(ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6], ORDER_W'(i));
    // right angles, full turn wrap and just off a right angle
    send_angles(ANGLE_W'(23040), ANGLE_W'(46080), ANGLE_W'(69120), ORD_XYZ);
    send_angles(ANGLE_W'(-23040), ANGLE_W'(-46080), ANGLE_W'(-69120), ORD_ZYX);
    send_angles(ANGLE_W'(115200), ANGLE_W'(-115200), ANGLE_W'(92161), ORD_ZXY);
    send_angles(ANGLE_W'(23039), ANGLE_W'(23041), ANGLE_W'(-1), ORD_YZX);
    send_angles(18'h3FFFF, 18'h2AAAA, 18'h15555, 3'd7);
    idle_cycles(1);
  endtask

  task automatic test_orders_in_range();
    ready_mode = 1;
    send_stream(700, 1);
  endtask

  task automatic test_right_angles();
    ready_mode = 2;
    send_stream(300, 0);
  endtask

  task automatic test_full_range();
    ready_mode = 0;
    send_stream(450, 2);
    ready_mode = 1;
    send_stream(480, 2);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (ready_mode)
      0: matrix.ready <= 1'b1;
      1: matrix.ready <= ($urandom_range(0, 3) != 0);
      default: matrix.ready <= !((cyc % 13) < 4 || (cyc % 29) == 7);
    endcase
  end

  always @(posedge clk) begin
    logic [143:0] want;
    logic [143:0] got;
    if (!rst && matrix.valid && matrix.ready) begin
      got = {matrix.r22, matrix.r21, matrix.r20, matrix.r12, matrix.r11, matrix.r10,
             matrix.r02, matrix.r01, matrix.r00};
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix transfer", $time);
        n_errors++;
      end else begin
        want = matrix_q.pop_front();
        for (int e = 0; e < 9; e++)
          if (got[e * 16 +: 16] !== want[e * 16 +: 16]) begin
            $display("%0t: r%0d%0d expected %0d actual %0d", $time, e / 3, e % 3,
                     $signed(want[e * 16 +: 16]), $signed(got[e * 16 +: 16]));
            n_errors++;
          end
        n_checked++;
      end
    end
  end

  initial begin
    angles.valid = 1'b0;
    angles.angle_x = '0;
    angles.angle_y = '0;
    angles.angle_z = '0;
    angles.axis_order = '0;
    for (int i = 0; i < MAX_STAGES; i++) atan_tab[i] = arctan_q40(i);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_orders_in_range();
    test_right_angles();
    test_full_range();
    idle_cycles(1);
    ready_mode = 1;
    for (int w = 0; w < 20000 && matrix_q.size() != 0; w++) @(posedge clk);
    repeat (STAGES + 20) @(posedge clk);
    if (matrix_q.size() != 0) begin
      $display("%0d matrices never arrived", matrix_q.size());
      n_errors++;
    end
    $display("sent %0d angle triples over all axis orders, checked %0d matrices", n_sent,
             n_checked);
    $display("covered right angles, wrap past a full turn and full 18-bit angles");
    if (n_errors == 0) $display("** euler_to_rotation_matrix: PASSED **");
    else $display("** euler_to_rotation_matrix: FAILED **");
    $finish;
  end

  initial begin
    #4ms;
    $display("** euler_to_rotation_matrix: FAILED **");
    $finish;
  end

endmodule
